### sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define AMAF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define AMAF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/amaf_pkg.sv
// package: payload types and fixed constants of the angle filter
package amaf_pkg;

	localparam int RAW_W        = 12;
	localparam int DEG_W        = 9;
	localparam int DEG_PER_TURN = 360;
	localparam int DEG_MAX      = 359;

	typedef struct packed {
		logic [RAW_W-1:0] raw_angle;
	} sample_t;

	typedef struct packed {
		logic [DEG_W-1:0] angle_deg;
		logic [DEG_W-1:0] median_deg;
		logic [DEG_W-1:0] filtered_deg;
	} result_t;

endpackage

### sv/amaf_stream_if.sv
// interface: valid/ready channel with a typed payload
interface amaf_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/amaf_ram.sv
// generic single-port-write, single-port-read ram with registered read
module amaf_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/amaf_div.sv
// restoring divider, one quotient bit per cycle
module amaf_div #(
	parameter int SUM_W = 12,
	parameter int DIV_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);
	localparam int CW = $clog2(SUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [SUM_W-1:0] quo_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   rem_dif;
	logic             fits;

	always_comb begin
		rem_sh  = {rem_q, quo_q[SUM_W-1]};
		fits    = rem_sh >= {1'b0, dsr_q};
		rem_dif = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(SUM_W - 1);
			rem_q  <= '0;
			dsr_q  <= divisor;
			quo_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_dif[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### sv/angle_median_average_filter.sv
// top level: degree scaling, ram-based window median and moving average
// one sample is taken at a time: sample.ready is high only in the idle state, so a new sample
// waits until the previous result has been loaded into the output register
// the rank scan reads the median window ram once per cycle
// arst_n clears pointers, fill count, running sum, entry valid bits and the output valid
// window entries never written read as zero; ram contents themselves are not reset
module angle_median_average_filter
	import amaf_pkg::*;
#(
	parameter int MEDIAN_TAPS  = 5,
	parameter int AVERAGE_TAPS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	amaf_stream_if.sink   sample,
	amaf_stream_if.source result
);
	localparam int MIDX_W = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
	localparam int AIDX_W = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
	localparam int CNT_W  = $clog2(MEDIAN_TAPS + 1);
	localparam int FILL_W = $clog2(AVERAGE_TAPS + 1);
	localparam int SUM_W  = $clog2(AVERAGE_TAPS * DEG_MAX + 1);
	localparam int PROD_W = RAW_W + DEG_W;
	localparam int K_LO   = (MEDIAN_TAPS - 1) / 2;
	localparam int K_HI   = MEDIAN_TAPS / 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_AVG_RD,
		ST_AVG_UPD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [MIDX_W-1:0]       mptr_q;
	logic [MEDIAN_TAPS-1:0]  mvalid_q;
	logic [AIDX_W-1:0]       aptr_q;
	logic [AVERAGE_TAPS-1:0] avalid_q;
	logic [FILL_W-1:0]       fill_q;
	logic [SUM_W-1:0]        sum_q;

	logic [CNT_W-1:0]  phase_q;
	logic [CNT_W-1:0]  phase_m1;
	logic [MIDX_W-1:0] cand_q;
	logic              rvld_s1;
	logic              cand_s1;
	logic              last_s1;
	logic [MIDX_W-1:0] midx_s1;
	logic [DEG_W-1:0]  cval_q;
	logic [CNT_W-1:0]  less_q;
	logic [CNT_W-1:0]  eq_q;
	logic [CNT_W-1:0]  less_n;
	logic [CNT_W-1:0]  eq_n;
	logic [CNT_W-1:0]  upper_n;
	logic [DEG_W-1:0]  lo_q;
	logic [DEG_W-1:0]  hi_q;
	logic [DEG_W-1:0]  deg_q;
	logic [DEG_W-1:0]  med_q;

	logic [PROD_W-1:0] prod;
	logic [DEG_W-1:0]  deg;
	logic              take;
	logic              out_free;
	logic              out_load;
	logic              out_valid_q;
	result_t           res_q;

	logic              m_we;
	logic [MIDX_W-1:0] m_raddr;
	logic [DEG_W-1:0]  m_rdata;
	logic [DEG_W-1:0]  mval;
	logic              a_we;
	logic [DEG_W-1:0]  a_rdata;
	logic [DEG_W-1:0]  aold;
	logic [DEG_W:0]    pair_sum;
	logic [DEG_W-1:0]  med;
	logic [SUM_W-1:0]  sum_next;
	logic [FILL_W-1:0] fill_next;

	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  div_quo;

	// degree scaling: floor(raw * 360 / 4096)
	always_comb begin
		prod = PROD_W'(sample.data.raw_angle) * PROD_W'(DEG_PER_TURN);
		deg  = prod[PROD_W-1:RAW_W];
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign take         = sample.valid && sample.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign out_load     = out_free && ((state_q == ST_DIV && div_done) || (state_q == ST_DONE));

	// scan address: candidate first, then every entry for ranking
	always_comb begin
		phase_m1 = phase_q - CNT_W'(1);
		m_raddr  = (phase_q == '0) ? cand_q : phase_m1[MIDX_W-1:0];
		m_we     = take;
		mval     = mvalid_q[midx_s1] ? m_rdata : '0;
		less_n   = less_q + CNT_W'(mval < cval_q);
		eq_n     = eq_q + CNT_W'(mval == cval_q);
		upper_n  = less_n + eq_n;
	end

	// average update
	always_comb begin
		aold      = avalid_q[aptr_q] ? a_rdata : '0;
		pair_sum  = {1'b0, lo_q} + {1'b0, hi_q};
		med       = pair_sum[DEG_W:1];
		sum_next  = sum_q - SUM_W'(aold) + SUM_W'(med);
		fill_next = (fill_q == FILL_W'(AVERAGE_TAPS)) ? fill_q : fill_q + FILL_W'(1);
		a_we      = (state_q == ST_AVG_UPD);
		div_start = a_we;
	end

	amaf_ram #(
		.WIDTH (DEG_W),
		.DEPTH (MEDIAN_TAPS)
	) u_med_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (mptr_q),
		.wdata (deg),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	amaf_ram #(
		.WIDTH (DEG_W),
		.DEPTH (AVERAGE_TAPS)
	) u_avg_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (aptr_q),
		.wdata (med),
		.raddr (aptr_q),
		.rdata (a_rdata)
	);

	amaf_div #(
		.SUM_W (SUM_W),
		.DIV_W (FILL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (fill_next),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mptr_q      <= '0;
			mvalid_q    <= '0;
			aptr_q      <= '0;
			avalid_q    <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			phase_q     <= '0;
			cand_q      <= '0;
			rvld_s1     <= 1'b0;
			cand_s1     <= 1'b0;
			last_s1     <= 1'b0;
			midx_s1     <= '0;
			cval_q      <= '0;
			less_q      <= '0;
			eq_q        <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			deg_q       <= '0;
			med_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			// ranking of the registered read data
			rvld_s1 <= (state_q == ST_SCAN);
			if (rvld_s1) begin
				if (cand_s1) begin
					cval_q <= mval;
					less_q <= '0;
					eq_q   <= '0;
				end else begin
					less_q <= less_n;
					eq_q   <= eq_n;
					if (last_s1) begin
						if (less_n <= CNT_W'(K_LO) && CNT_W'(K_LO) < upper_n) begin
							lo_q <= cval_q;
						end
						if (less_n <= CNT_W'(K_HI) && CNT_W'(K_HI) < upper_n) begin
							hi_q <= cval_q;
						end
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (take) begin
						deg_q            <= deg;
						mvalid_q[mptr_q] <= 1'b1;
						mptr_q           <= (mptr_q == MIDX_W'(MEDIAN_TAPS - 1)) ?
							'0 : mptr_q + MIDX_W'(1);
						phase_q          <= '0;
						cand_q           <= '0;
						state_q          <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cand_s1 <= (phase_q == '0);
					last_s1 <= (phase_q == CNT_W'(MEDIAN_TAPS));
					midx_s1 <= m_raddr;
					if (phase_q == CNT_W'(MEDIAN_TAPS)) begin
						phase_q <= '0;
						if (cand_q == MIDX_W'(MEDIAN_TAPS - 1)) begin
							state_q <= ST_DRAIN;
						end else begin
							cand_q <= cand_q + MIDX_W'(1);
						end
					end else begin
						phase_q <= phase_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_AVG_RD;
				end
				ST_AVG_RD: begin
					state_q <= ST_AVG_UPD;
				end
				ST_AVG_UPD: begin
					med_q            <= med;
					sum_q            <= sum_next;
					fill_q           <= fill_next;
					avalid_q[aptr_q] <= 1'b1;
					aptr_q           <= (aptr_q == AIDX_W'(AVERAGE_TAPS - 1)) ?
						'0 : aptr_q + AIDX_W'(1);
					state_q          <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (out_free) begin
							res_q.angle_deg    <= deg_q;
							res_q.median_deg   <= med_q;
							res_q.filtered_deg <= div_quo[DEG_W-1:0];
							state_q            <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_q.angle_deg    <= deg_q;
						res_q.median_deg   <= med_q;
						res_q.filtered_deg <= div_quo[DEG_W-1:0];
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;
endmodule

### sv/amaf_checker.sv
// checker: port-level assertions for the angle filter, bound to the top level
`include "assert_macros.svh"

module amaf_checker
	import amaf_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [DEG_W-1:0] angle_deg,
	input logic [DEG_W-1:0] median_deg,
	input logic [DEG_W-1:0] filtered_deg
);
	`AMAF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({angle_deg, median_deg, filtered_deg}))
	`AMAF_ASSERT_SAME(a_out_range, out_valid, angle_deg <= DEG_W'(DEG_MAX) && median_deg <= DEG_W'(DEG_MAX) && filtered_deg <= DEG_W'(DEG_MAX))
	`AMAF_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
	`AMAF_ASSERT_SAME(a_out_from_work, $rose(out_valid), !$past(in_ready))
endmodule

bind angle_median_average_filter amaf_checker u_amaf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.angle_deg    (result.data.angle_deg),
	.median_deg   (result.data.median_deg),
	.filtered_deg (result.data.filtered_deg)
);
